[sv/per_device_token_bucket_top_macros.svh]
// ----------------------------------------------------------------------------
// per_device_token_bucket_top assertion macros
// shared property wrappers for the throttle block
// ----------------------------------------------------------------------------
`ifndef PER_DEVICE_TOKEN_BUCKET_TOP_MACROS_SVH
`define PER_DEVICE_TOKEN_BUCKET_TOP_MACROS_SVH

// same-cycle implication
`define PTB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PTB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ptb_pkg.sv]
// ----------------------------------------------------------------------------
// ptb_pkg
// shared widths, constants and controller command type
// ----------------------------------------------------------------------------
package ptb_pkg;

	localparam int unsigned ID_W   = 64;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned TOK_W  = 16;
	localparam int unsigned IN_W   = 96;
	localparam int unsigned OUT_W  = 24;

	localparam logic [TOK_W-1:0] CAPACITY_RESET = 16'd1000;

	typedef struct packed {
		logic capture;
		logic look;
		logic read;
		logic refill;
		logic write;
	} ptb_cmd_t;

endpackage

[sv/ptb_datapath.sv]
// ----------------------------------------------------------------------------
// ptb_datapath
// slot table, lookup, refill arithmetic and result register
// ----------------------------------------------------------------------------
module ptb_datapath import ptb_pkg::*; #(
	parameter int unsigned NUM_SLOTS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ptb_cmd_t          cmd,
	input  logic              cfg_we,
	input  logic [TOK_W-1:0]  cfg_data,
	input  logic [IN_W-1:0]   s_tdata,
	output logic [OUT_W-1:0]  m_tdata
);

	localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic [TOK_W-1:0]  cap_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] now_q;

	logic [ID_W-1:0]   owner_q [NUM_SLOTS];
	logic [TOK_W-1:0]  tok_mem [NUM_SLOTS];
	logic [TIME_W-1:0] last_mem [NUM_SLOTS];

	logic [IW-1:0]     hit_idx;
	logic [IW-1:0]     free_idx;
	logic              hit_any;
	logic              free_any;

	logic [IW-1:0]     idx_q;
	logic              found_q;
	logic              fresh_q;
	logic              zero_q;

	logic [TOK_W-1:0]  tok_rd_q;
	logic [TIME_W-1:0] last_rd_q;

	logic [TOK_W-1:0]  tok_sel;
	logic [TIME_W-1:0] last_sel;
	logic [TIME_W-1:0] elapsed;
	logic [TIME_W:0]   sum;
	logic [TOK_W-1:0]  tok_ref;
	logic [TOK_W-1:0]  tok_ref_q;

	logic              bypass;
	logic              tok_empty;
	logic [TOK_W-1:0]  tok_dec;

	logic              out_granted_q;
	logic              out_bypassed_q;
	logic              out_new_q;
	logic [TOK_W-1:0]  out_tokens_q;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_data;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			id_q  <= s_tdata[ID_W-1:0];
			now_q <= s_tdata[ID_W+TIME_W-1:ID_W];
		end
	end

	// parallel owner compare, lowest slot wins
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		hit_any  = 1'b0;
		free_any = 1'b0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (owner_q[i] == id_q) begin
				hit_idx = IW'(i);
				hit_any = 1'b1;
			end
			if (owner_q[i] == '0) begin
				free_idx = IW'(i);
				free_any = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			zero_q  <= (id_q == '0);
			found_q <= hit_any || free_any;
			fresh_q <= !hit_any;
			idx_q   <= hit_any ? hit_idx : free_idx;
		end
	end

	// owner table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				owner_q[i] <= '0;
			end
		end else if (cmd.write && found_q && !zero_q) begin
			owner_q[idx_q] <= id_q;
		end
	end

	// bucket memories
	always_ff @(posedge clk) begin
		if (cmd.write && found_q && !zero_q) begin
			tok_mem[idx_q]  <= tok_empty ? tok_ref_q : tok_dec;
			last_mem[idx_q] <= now_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			tok_rd_q  <= tok_mem[idx_q];
			last_rd_q <= last_mem[idx_q];
		end
	end

	// refill
	always_comb begin
		tok_sel  = fresh_q ? cap_q : tok_rd_q;
		last_sel = fresh_q ? now_q : last_rd_q;
		elapsed  = now_q - last_sel;
		sum      = {{(TIME_W + 1 - TOK_W){1'b0}}, tok_sel} + {1'b0, elapsed};
		if (elapsed != '0 && sum > {{(TIME_W + 1 - TOK_W){1'b0}}, cap_q}) begin
			tok_ref = cap_q;
		end else begin
			tok_ref = sum[TOK_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.refill) begin
			tok_ref_q <= tok_ref;
		end
	end

	// spend and result
	assign bypass    = zero_q || !found_q;
	assign tok_empty = (tok_ref_q == '0);
	assign tok_dec   = tok_ref_q - TOK_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			out_granted_q  <= bypass || !tok_empty;
			out_bypassed_q <= bypass;
			out_new_q      <= !bypass && fresh_q;
			out_tokens_q   <= (bypass || tok_empty) ? '0 : tok_dec;
		end
	end

	assign m_tdata = {{(OUT_W - TOK_W - 3){1'b0}}, out_tokens_q, out_new_q,
		out_bypassed_q, out_granted_q};

endmodule

[sv/ptb_ctrl.sv]
// ----------------------------------------------------------------------------
// ptb_ctrl
// request sequencer and output beat handshake
// ----------------------------------------------------------------------------
`include "per_device_token_bucket_top_macros.svh"

module ptb_ctrl import ptb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output ptb_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_READ,
		S_REFILL,
		S_WRITE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.capture = (state_q == S_IDLE) && s_tvalid;
		cmd.look    = (state_q == S_LOOK);
		cmd.read    = (state_q == S_READ);
		cmd.refill  = (state_q == S_REFILL);
		cmd.write   = (state_q == S_WRITE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && !cmd.write) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK:   state_q <= S_READ;
				S_READ:   state_q <= S_REFILL;
				S_REFILL: state_q <= S_WRITE;
				S_WRITE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PTB_ASSERT_NOW(a_write_needs_room, clk, arst_n, cmd.write,
		!out_valid_q || m_tready, "result overwritten before taken")
	`PTB_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready,
		!s_tready, "second request accepted while busy")
	`PTB_ASSERT_NEXT(a_result_from_write, clk, arst_n, cmd.write,
		m_tvalid && s_tready, "write did not post a result")

endmodule

[sv/per_device_token_bucket_top.sv]
// ----------------------------------------------------------------------------
// per_device_token_bucket_top
// per-device token bucket throttle with a small slot table
// ----------------------------------------------------------------------------
// Each request beat passes in turn through capture, a parallel compare of the id
// against every slot owner, a registered read of the chosen bucket, the refill
// add and clamp, and the spend with table write. One request is worked on at a
// time, so no new beat is taken until the last one is written; the result sits
// in an output register, and the next request is taken while it waits, stalling
// only in the write step if the previous result is still not taken.
module per_device_token_bucket_top import ptb_pkg::*; #(
	parameter int unsigned NUM_SLOTS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [TOK_W-1:0]  cfg_data,     // token_capacity
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,      // device_id[63:0], now_ms[95:64]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata       // granted, bypassed, new_slot, tokens_left[18:3]
);

	ptb_cmd_t cmd;

	ptb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	ptb_datapath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.m_tdata  (m_tdata)
	);

endmodule
